// ----- hw/rtl/nldc_pkg.sv -----
// nldc_pkg: widths, register indexes and saturation helpers for the
// normal lighting and depth cue pipeline; no dependencies

package nldc_pkg;

   localparam int NRM_W  = 16;
   localparam int CH_W   = 8;
   localparam int ROW_W  = 48;
   localparam int RGB_W  = 24;
   localparam int INT_W  = 15;
   localparam int ACC_W  = 34;
   localparam int FRAC_W = 12;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_LIGHT_ROW_0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LIGHT_ROW_1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LIGHT_ROW_2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_ROW_0 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_ROW_1 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COLOR_ROW_2 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_AMBIENT     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_FOG         = 3'd7;

   localparam logic [0:0] ACTION_FOG_ONLY = 1'b0;
   localparam logic [0:0] ACTION_LIGHT    = 1'b1;

   // shift right by 12 and clamp to 0..32767
   function automatic logic [INT_W-1:0] sat_intensity(input logic signed [ACC_W-1:0] s);
      logic signed [ACC_W-FRAC_W-1:0] q;
      q = (ACC_W-FRAC_W)'(s >>> FRAC_W);
      if (q < 0) sat_intensity = '0;
      else if (q > 22'sd32767) sat_intensity = '1;
      else sat_intensity = q[INT_W-1:0];
   endfunction

   // clamp the scaled fog difference to a signed 16-bit value
   function automatic logic signed [NRM_W-1:0] sat_s16(input logic signed [16:0] q);
      if (q > 17'sd32767) sat_s16 = 16'sh7fff;
      else if (q < -17'sd32768) sat_s16 = 16'sh8000;
      else sat_s16 = q[NRM_W-1:0];
   endfunction

   // clamp the final channel to 0..255
   function automatic logic [CH_W-1:0] sat_u8(input logic signed [17:0] q);
      if (q < 0) sat_u8 = '0;
      else if (q > 18'sd255) sat_u8 = '1;
      else sat_u8 = q[CH_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/normal_light_depth_cue.sv -----
// normal_light_depth_cue: pipelined vertex lighting with fog blend
// depends on nldc_pkg
//
//   channel  dir    handshake                  payload
//   req      in     req_tvalid / req_tready    tdata 96 bits, tuser = action
//   rsp      out    rsp_tvalid / rsp_tready    tdata 32 bits
//   csr      in     psel/penable/pwrite        eight registers at 8*i
//
// seven register stages: light multiply, light sum, color multiply, color sum,
// tint and fog difference, fog multiply, blend into the output register
// one item per cycle while the output is not stalled; reset clears the valid bits and the csr registers
// when the output holds an item that is not taken the whole pipe holds still

module normal_light_depth_cue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // normal_x, normal_y, normal_z, color_r, color_g, color_b, color_code, fog_factor
   input  logic [nldc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_r, out_g, out_b, out_code
   output logic [nldc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nldc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nldc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nldc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [nldc_pkg::ROW_W-1:0] light_row_ff [3];
   logic [nldc_pkg::ROW_W-1:0] color_row_ff [3];
   logic [nldc_pkg::RGB_W-1:0] ambient_ff;
   logic [nldc_pkg::RGB_W-1:0] fog_ff;
   logic [nldc_pkg::REG_IDX_W-1:0] reg_idx;

   logic       advance;
   logic [6:1] valid_ff;
   logic [6:1] valid_in;

   logic signed [nldc_pkg::NRM_W-1:0] nrm [3];
   logic [nldc_pkg::CH_W-1:0]         req_col [3];

   // stage payloads
   logic signed [31:0]               prod1_ff [3][3];
   logic [nldc_pkg::INT_W-1:0]       illum_ff [3];
   logic signed [31:0]               prod3_ff [3][3];
   logic [nldc_pkg::INT_W-1:0]       inten_ff [3];
   logic [26:0]                      c5_ff [3];
   logic signed [nldc_pkg::NRM_W-1:0] d5_ff [3];
   logic [26:0]                      c6_ff [3];
   logic signed [31:0]               prod6_ff [3];
   logic [nldc_pkg::CH_W-1:0]        out_ff [3];

   logic [0:0]                       act_ff [1:4];
   logic [nldc_pkg::CH_W-1:0]        col_ff [1:4][3];
   logic [nldc_pkg::CH_W-1:0]        code_ff [1:6];
   logic [nldc_pkg::CH_W-1:0]        out_code_ff;
   logic signed [nldc_pkg::NRM_W-1:0] dc_ff [1:5];

   logic signed [nldc_pkg::ACC_W-1:0] sum2 [3];
   logic signed [nldc_pkg::ACC_W-1:0] sum4 [3];
   logic [26:0]                       c5_in [3];
   logic signed [nldc_pkg::NRM_W-1:0] d5_in [3];
   logic [nldc_pkg::CH_W-1:0]         out_in [3];
   logic [22:0]                       tint [3];
   logic signed [28:0]                diff [3];
   logic signed [nldc_pkg::ACC_W-1:0] sum7 [3];

   // configuration port
   assign reg_idx    = csr_paddr[nldc_pkg::CSR_ADDR_W-1 -: nldc_pkg::REG_IDX_W];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            light_row_ff[i] <= '0;
            color_row_ff[i] <= '0;
         end
         ambient_ff <= '0;
         fog_ff     <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            nldc_pkg::REG_LIGHT_ROW_0: light_row_ff[0] <= csr_pwdata[nldc_pkg::ROW_W-1:0];
            nldc_pkg::REG_LIGHT_ROW_1: light_row_ff[1] <= csr_pwdata[nldc_pkg::ROW_W-1:0];
            nldc_pkg::REG_LIGHT_ROW_2: light_row_ff[2] <= csr_pwdata[nldc_pkg::ROW_W-1:0];
            nldc_pkg::REG_COLOR_ROW_0: color_row_ff[0] <= csr_pwdata[nldc_pkg::ROW_W-1:0];
            nldc_pkg::REG_COLOR_ROW_1: color_row_ff[1] <= csr_pwdata[nldc_pkg::ROW_W-1:0];
            nldc_pkg::REG_COLOR_ROW_2: color_row_ff[2] <= csr_pwdata[nldc_pkg::ROW_W-1:0];
            nldc_pkg::REG_AMBIENT:     ambient_ff      <= csr_pwdata[nldc_pkg::RGB_W-1:0];
            nldc_pkg::REG_FOG:         fog_ff          <= csr_pwdata[nldc_pkg::RGB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         nldc_pkg::REG_LIGHT_ROW_0: csr_prdata = 64'(light_row_ff[0]);
         nldc_pkg::REG_LIGHT_ROW_1: csr_prdata = 64'(light_row_ff[1]);
         nldc_pkg::REG_LIGHT_ROW_2: csr_prdata = 64'(light_row_ff[2]);
         nldc_pkg::REG_COLOR_ROW_0: csr_prdata = 64'(color_row_ff[0]);
         nldc_pkg::REG_COLOR_ROW_1: csr_prdata = 64'(color_row_ff[1]);
         nldc_pkg::REG_COLOR_ROW_2: csr_prdata = 64'(color_row_ff[2]);
         nldc_pkg::REG_AMBIENT:     csr_prdata = 64'(ambient_ff);
         nldc_pkg::REG_FOG:         csr_prdata = 64'(fog_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // pipeline control
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[5:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rsp_tvalid <= 1'b0;
      end else if (advance) begin
         valid_ff   <= valid_in;
         rsp_tvalid <= valid_ff[6];
      end
   end

   // input fields
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         nrm[j]     = $signed(req_tdata[16*j +: 16]);
         req_col[j] = req_tdata[48 + 8*j +: 8];
      end
   end

   // datapath arithmetic between stages
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum2[i] = 34'(prod1_ff[i][0]) + 34'(prod1_ff[i][1]) + 34'(prod1_ff[i][2]);
         sum4[i] = $signed(34'({ambient_ff[8*i +: 8], 16'b0}))
                   + 34'(prod3_ff[i][0]) + 34'(prod3_ff[i][1]) + 34'(prod3_ff[i][2]);
         tint[i] = 23'(col_ff[4][i]) * 23'(inten_ff[i]);
         if (act_ff[4] == nldc_pkg::ACTION_LIGHT) c5_in[i] = {tint[i], 4'b0};
         else c5_in[i] = {3'b0, col_ff[4][i], 16'b0};
         diff[i]  = $signed({5'b0, fog_ff[8*i +: 8], 16'b0}) - $signed({2'b0, c5_in[i]});
         d5_in[i] = nldc_pkg::sat_s16(17'(diff[i] >>> 12));
         sum7[i]  = $signed({7'b0, c6_ff[i]}) + 34'(prod6_ff[i]);
         out_in[i] = nldc_pkg::sat_u8(18'(sum7[i] >>> 16));
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod1_ff[i][j] <= $signed(light_row_ff[i][16*j +: 16]) * nrm[j];
               prod3_ff[i][j] <= $signed(color_row_ff[i][16*j +: 16])
                                 * $signed({1'b0, illum_ff[j]});
            end
            illum_ff[i]  <= nldc_pkg::sat_intensity(sum2[i]);
            inten_ff[i]  <= nldc_pkg::sat_intensity(sum4[i]);
            c5_ff[i]     <= c5_in[i];
            d5_ff[i]     <= d5_in[i];
            c6_ff[i]     <= c5_ff[i];
            prod6_ff[i]  <= d5_ff[i] * dc_ff[5];
            out_ff[i]    <= out_in[i];
            col_ff[1][i] <= req_col[i];
            for (int k = 2; k <= 4; k++) col_ff[k][i] <= col_ff[k-1][i];
         end
         act_ff[1]  <= req_tuser;
         for (int k = 2; k <= 4; k++) act_ff[k] <= act_ff[k-1];
         code_ff[1] <= req_tdata[72 +: 8];
         for (int k = 2; k <= 6; k++) code_ff[k] <= code_ff[k-1];
         out_code_ff <= code_ff[6];
         dc_ff[1]   <= $signed(req_tdata[80 +: 16]);
         for (int k = 2; k <= 5; k++) dc_ff[k] <= dc_ff[k-1];
      end
   end

   assign rsp_tdata = {out_code_ff, out_ff[2], out_ff[1], out_ff[0]};

endmodule

// ----- test/normal_light_depth_cue_tb.sv -----
`timescale 1ns / 100ps
// normal_light_depth_cue_tb: stream testbench for the vertex lighting and fog blend unit
// checks every result against an in-bench prediction built from the csr settings
// depends on nldc_pkg and normal_light_depth_cue

module normal_light_depth_cue_tb;

   typedef struct packed {
      logic [0:0]  action;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  code;
      logic [15:0] dc;
   } vertex_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [nldc_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic [0:0]                       req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [nldc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [nldc_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [nldc_pkg::CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [nldc_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                             csr_pready;

   vertex_type    pending_vertices[$];
   logic [31:0]   expected_colors[$];
   vertex_type    offered_vertex;
   logic [47:0]   light_rows[3];
   logic [47:0]   color_rows[3];
   logic [23:0]   ambient_rgb = '0;
   logic [23:0]   fog_rgb = '0;
   int            mismatches = 0;
   int            send_gap = 0;
   int            rsp_hold = 0;
   int            long_hold_requests = 0;
   int            long_hold_served = 0;
   bit            idle_enable = 1'b1;

   normal_light_depth_cue uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint clamp_range(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   function automatic logic [7:0] blend_to_fog(longint c, logic [7:0] fog, longint dc);
      longint d;
      d = clamp_range(((longint'(fog) * 65536) - c) >>> 12, -32768, 32767);
      return 8'(clamp_range((c + d * dc) >>> 16, 0, 255));
   endfunction

   function automatic logic [31:0] predict_color(vertex_type v);
      longint nrm[3];
      longint illum[3];
      longint s;
      longint inten;
      longint dc;
      logic [7:0] col[3];
      logic [7:0] chan[3];
      begin
         nrm[0] = sx16(v.nx);
         nrm[1] = sx16(v.ny);
         nrm[2] = sx16(v.nz);
         col[0] = v.r;
         col[1] = v.g;
         col[2] = v.b;
         dc = sx16(v.dc);
         if (v.action == nldc_pkg::ACTION_LIGHT) begin
            for (int i = 0; i < 3; i++) begin
               s = 0;
               for (int j = 0; j < 3; j++)
                  s += sx16(light_rows[i][16*j +: 16]) * nrm[j];
               illum[i] = clamp_range(s >>> 12, 0, 32767);
            end
            for (int i = 0; i < 3; i++) begin
               s = longint'(ambient_rgb[8*i +: 8]) * 65536;
               for (int j = 0; j < 3; j++)
                  s += sx16(color_rows[i][16*j +: 16]) * illum[j];
               inten = clamp_range(s >>> 12, 0, 32767);
               chan[i] = blend_to_fog(longint'(col[i]) * inten * 16, fog_rgb[8*i +: 8], dc);
            end
         end else begin
            for (int i = 0; i < 3; i++)
               chan[i] = blend_to_fog(longint'(col[i]) * 65536, fog_rgb[8*i +: 8], dc);
         end
         return {v.code, chan[2], chan[1], chan[0]};
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
   endtask

   // driver: offers pending items, holds each until taken
   always @(posedge clock) begin : drive_req
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_colors.push_back(predict_color(offered_vertex));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 14) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_vertices.size() > 0) begin
               offered_vertex = pending_vertices.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {offered_vertex.dc, offered_vertex.code, offered_vertex.b,
                             offered_vertex.g, offered_vertex.r, offered_vertex.nz,
                             offered_vertex.ny, offered_vertex.nx};
               req_tuser <= offered_vertex.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result item and paces rsp_tready
   always @(posedge clock) begin : watch_rsp
      logic [31:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch("unexpected item", '0, rsp_tdata);
            end else begin
               want = expected_colors.pop_front();
               if (rsp_tdata[7:0] !== want[7:0])
                  report_mismatch("out_r", want, rsp_tdata);
               if (rsp_tdata[15:8] !== want[15:8])
                  report_mismatch("out_g", want, rsp_tdata);
               if (rsp_tdata[23:16] !== want[23:16])
                  report_mismatch("out_b", want, rsp_tdata);
               if (rsp_tdata[31:24] !== want[31:24])
                  report_mismatch("out_code", want, rsp_tdata);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else if (long_hold_requests > long_hold_served) begin
            long_hold_served++;
            rsp_hold = 299;
            rsp_tready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_hold = $urandom_range(1, 14) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(logic [nldc_pkg::REG_IDX_W-1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         nldc_pkg::REG_LIGHT_ROW_0: light_rows[0] = val[47:0];
         nldc_pkg::REG_LIGHT_ROW_1: light_rows[1] = val[47:0];
         nldc_pkg::REG_LIGHT_ROW_2: light_rows[2] = val[47:0];
         nldc_pkg::REG_COLOR_ROW_0: color_rows[0] = val[47:0];
         nldc_pkg::REG_COLOR_ROW_1: color_rows[1] = val[47:0];
         nldc_pkg::REG_COLOR_ROW_2: color_rows[2] = val[47:0];
         nldc_pkg::REG_AMBIENT:     ambient_rgb = val[23:0];
         nldc_pkg::REG_FOG:         fog_rgb = val[23:0];
      endcase
   endtask

   task automatic load_lighting(logic [63:0] l0, logic [63:0] l1, logic [63:0] l2,
                                logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                                logic [63:0] amb, logic [63:0] fog);
      write_csr(nldc_pkg::REG_LIGHT_ROW_0, l0);
      write_csr(nldc_pkg::REG_LIGHT_ROW_1, l1);
      write_csr(nldc_pkg::REG_LIGHT_ROW_2, l2);
      write_csr(nldc_pkg::REG_COLOR_ROW_0, c0);
      write_csr(nldc_pkg::REG_COLOR_ROW_1, c1);
      write_csr(nldc_pkg::REG_COLOR_ROW_2, c2);
      write_csr(nldc_pkg::REG_AMBIENT, amb);
      write_csr(nldc_pkg::REG_FOG, fog);
   endtask

   // sampled at the falling edge so the driver and monitor updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_vertices.size() != 0 || req_tvalid || expected_colors.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_vertex(logic [0:0] action, logic [15:0] nx, logic [15:0] ny,
                               logic [15:0] nz, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic [7:0] code, logic [15:0] dc);
      vertex_type v;
      v = '{action, nx, ny, nz, r, g, b, code, dc};
      pending_vertices.push_back(v);
   endtask

   function automatic logic [15:0] rand_entry();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 8192)) - 16'd4096;
         2: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               3: return 16'h1000;
               default: return 16'hffff;
            endcase
         end
         default: return 16'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] rand_row();
      return {16'($urandom), rand_entry(), rand_entry(), rand_entry()};
   endfunction

   function automatic logic [63:0] rand_rgb();
      return {32'($urandom), 8'($urandom), rand_byte(), rand_byte(), rand_byte()};
   endfunction

   function automatic vertex_type rand_vertex();
      vertex_type v;
      v.action = 1'($urandom_range(0, 1));
      v.nx = rand_entry();
      v.ny = rand_entry();
      v.nz = rand_entry();
      v.r = rand_byte();
      v.g = rand_byte();
      v.b = rand_byte();
      v.code = 8'($urandom);
      case ($urandom_range(0, 3))
         0: v.dc = 16'($urandom_range(0, 4096));
         1: v.dc = 16'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0: v.dc = 16'h0000;
               1: v.dc = 16'h1000;
               2: v.dc = 16'h7fff;
               default: v.dc = 16'h8000;
            endcase
         end
         default: v.dc = 16'($urandom_range(0, 2048));
      endcase
      return v;
   endfunction

   initial begin
      #(20 * 400000);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < 3; i++) begin
         light_rows[i] = '0;
         color_rows[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: everything zero
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h1000, 16'h1000, 16'h1000,
                   8'hff, 8'hff, 8'hff, 8'h5a, 16'h0000);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h0000, 16'h0000, 16'h0000,
                   8'hff, 8'h80, 8'h01, 8'ha5, 16'h0800);
      wait_drained();

      // identity matrices, mid ambient and fog
      load_lighting(64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000, 64'h0000_1000_0000_0000,
                    64'h0000_0000_0000_1000, 64'h0000_0000_1000_0000, 64'h0000_1000_0000_0000,
                    64'h0000_0000_0010_2030, 64'h0000_0000_0040_ff80);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h1000, 16'h0800, 16'h0400,
                   8'hff, 8'h80, 8'h40, 8'h00, 16'h0000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h7fff, 16'h7fff, 16'h7fff,
                   8'hff, 8'hff, 8'hff, 8'hff, 16'h0000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h8000, 16'h8000, 16'h8000,
                   8'hff, 8'hff, 8'hff, 8'h01, 16'h0000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h7fff, 16'h8000, 16'h0000,
                   8'h00, 8'h00, 8'h00, 8'h80, 16'h1000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h1000, 16'h1000, 16'h1000,
                   8'h80, 8'h80, 8'h80, 8'h7f, 16'h7fff);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h1000, 16'h1000, 16'h1000,
                   8'hff, 8'hff, 8'hff, 8'h3c, 16'h8000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'hf000, 16'h0fff, 16'h0001,
                   8'h10, 8'h20, 8'h30, 8'hc3, 16'h0800);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'hffff, 16'h0001, 16'h2000,
                   8'hff, 8'h00, 8'hff, 8'h11, 16'hffff);
      // fog only: normal fields ignored
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h7fff, 16'h8000, 16'h1234,
                   8'h00, 8'h00, 8'h00, 8'h22, 16'h0000);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'hffff, 16'hffff, 16'hffff,
                   8'hff, 8'hff, 8'hff, 8'h44, 16'h1000);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h0000, 16'h0000, 16'h0000,
                   8'h00, 8'hff, 8'h00, 8'h88, 16'h7fff);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h0000, 16'h0000, 16'h0000,
                   8'hff, 8'h00, 8'hff, 8'hee, 16'h8000);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h5555, 16'haaaa, 16'h0f0f,
                   8'h55, 8'haa, 8'h0f, 8'hf0, 16'h0800);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'haaaa, 16'h5555, 16'hf0f0,
                   8'haa, 8'h55, 8'hf0, 8'h0f, 16'hf800);
      wait_drained();

      // positive extremes everywhere, full ambient and white fog
      load_lighting(64'hffff_7fff_7fff_7fff, 64'hffff_7fff_7fff_7fff, 64'hffff_7fff_7fff_7fff,
                    64'hffff_7fff_7fff_7fff, 64'hffff_7fff_7fff_7fff, 64'hffff_7fff_7fff_7fff,
                    64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h7fff, 16'h7fff, 16'h7fff,
                   8'hff, 8'hff, 8'hff, 8'h01, 16'h8000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h8000, 16'h8000, 16'h8000,
                   8'h01, 8'h02, 8'h03, 8'h02, 16'h7fff);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h0000, 16'h0000, 16'h0000,
                   8'h00, 8'h00, 8'h00, 8'h03, 16'h1000);
      wait_drained();

      // negative extremes, black ambient and fog
      load_lighting(64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000,
                    64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000,
                    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h8000, 16'h8000, 16'h8000,
                   8'hff, 8'hff, 8'hff, 8'hfe, 16'h0000);
      queue_vertex(nldc_pkg::ACTION_LIGHT, 16'h7fff, 16'h7fff, 16'h7fff,
                   8'hff, 8'hff, 8'hff, 8'hfd, 16'h8000);
      queue_vertex(nldc_pkg::ACTION_FOG_ONLY, 16'h0000, 16'h0000, 16'h0000,
                   8'hff, 8'hff, 8'hff, 8'hfc, 16'h7fff);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         load_lighting(rand_row(), rand_row(), rand_row(), rand_row(), rand_row(), rand_row(),
                       rand_rgb(), rand_rgb());
         if (phase == 4)
            idle_enable = 1'b0;
         for (int n = 0; n < 110; n++)
            pending_vertices.push_back(rand_vertex());
         if (phase == 1)
            wait_drained();
         if (phase == 2)
            long_hold_requests++;
         for (int n = 0; n < 110; n++)
            pending_vertices.push_back(rand_vertex());
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (expected_colors.size() != 0)
         report_mismatch("missing item", expected_colors[0], '0);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
